>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg
// Types, constants and sign helpers for the segment/rectangle test.
// ----------------------------------------------------------------------------
`default_nettype none

package sri_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int NUM_CORNERS     = 4;
   localparam int NUM_EDGES       = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LEFT,
      REG_BOTTOM,
      REG_RIGHT,
      REG_TOP
   } csr_reg_type;

   // sign of a value: zero, negative, or positive when neither is set
   typedef struct packed {
      logic neg;
      logic zero;
   } sgn_type;

   typedef struct packed {
      sgn_type d3;        // edge direction vs segment start
      sgn_type d4;        // edge direction vs segment end
      logic    touch;     // an edge endpoint equals a segment endpoint
      logic    box_miss;  // bounding boxes are disjoint
   } edge_flags_type;

   typedef struct packed {
      logic                             reject;
      logic                             both_in;
      edge_flags_type [NUM_EDGES-1:0]   edges;
   } seg_flags_type;

   // sign of (a - b) from a < b and a == b
   function automatic sgn_type sgn_from_cmp(input logic lt, input logic eq);
      sgn_type s;
      s.neg  = lt;
      s.zero = eq;
      return s;
   endfunction

   function automatic sgn_type sgn_mul(input sgn_type a, input sgn_type b);
      sgn_type s;
      s.zero = a.zero | b.zero;
      s.neg  = ~s.zero & (a.neg ^ b.neg);
      return s;
   endfunction

   function automatic logic sgn_pos(input sgn_type a);
      return ~a.zero & ~a.neg;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sri_if.sv
// ----------------------------------------------------------------------------
// sri_if
// Valid/ready channels: segment items in, hit items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sri_seg_if #(
   parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sri_hit_if ();
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

`default_nettype wire

>>> rtl/sri_cross.sv
// ----------------------------------------------------------------------------
// sri_cross
// Two-stage exact cross products of the segment against the four corners.
// ----------------------------------------------------------------------------
`default_nettype none

module sri_cross #(
   parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [COORD_WIDTH:0]             seg_dx,
   input  logic signed [COORD_WIDTH:0]             seg_dy,
   input  logic signed [COORD_WIDTH:0]             dx_left,
   input  logic signed [COORD_WIDTH:0]             dx_right,
   input  logic signed [COORD_WIDTH:0]             dy_bottom,
   input  logic signed [COORD_WIDTH:0]             dy_top,
   output sri_pkg::sgn_type [sri_pkg::NUM_CORNERS-1:0] corner_sgn
);
   import sri_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int XW = PW + 1;

   logic signed [PW-1:0] p_xb_ff, p_xt_ff, p_ly_ff, p_ry_ff;
   logic signed [XW-1:0] cross_in [NUM_CORNERS];
   sgn_type [NUM_CORNERS-1:0] sgn_ff;

   // stage A: the four distinct products
   always_ff @(posedge clock) begin
      if (enable) begin
         p_xb_ff <= PW'(seg_dx) * PW'(dy_bottom);
         p_xt_ff <= PW'(seg_dx) * PW'(dy_top);
         p_ly_ff <= PW'(dx_left) * PW'(seg_dy);
         p_ry_ff <= PW'(dx_right) * PW'(seg_dy);
      end
   end

   // corners: 0 left-bottom, 1 left-top, 2 right-top, 3 right-bottom
   always_comb begin
      cross_in[0] = XW'(p_xb_ff) - XW'(p_ly_ff);
      cross_in[1] = XW'(p_xt_ff) - XW'(p_ly_ff);
      cross_in[2] = XW'(p_xt_ff) - XW'(p_ry_ff);
      cross_in[3] = XW'(p_xb_ff) - XW'(p_ry_ff);
   end

   // stage B: keep only the signs
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int c = 0; c < NUM_CORNERS; c++) begin
            sgn_ff[c].neg  <= cross_in[c][XW-1];
            sgn_ff[c].zero <= (cross_in[c] == '0);
         end
      end
   end

   assign corner_sgn = sgn_ff;

endmodule

`default_nettype wire

>>> rtl/segment_rectangle_intersect_top.sv
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_top
// Streaming test of line segments against a configured axis-aligned box.
// ----------------------------------------------------------------------------
// Each req item is a segment (start, end) in signed fixed point; each rsp
// item is one hit bit, set when the segment touches or crosses the
// rectangle given by the four csr registers (left, bottom, right, top;
// reset 0, corners used as written, an inverted box is not reordered).
// One item is taken every cycle while no result waits on rsp; each item
// then passes through the pipeline: input compares, the exact corner
// cross-product multipliers, the wide subtract to a sign, and the final
// sign logic into the rsp register. All stages advance together and hold
// only while a result waits on rsp. Write the csr registers only while no
// items are in flight. The only other state is the pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module segment_rectangle_intersect_top #(
   parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sri_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_wr_data,
   sri_seg_if.sink                             req_chan,
   sri_hit_if.source                           rsp_chan
);
   import sri_pkg::*;

   localparam int DW = COORD_WIDTH + 1;

   // configuration
   logic signed [COORD_WIDTH-1:0] left_ff, bottom_ff, right_ff, top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         bottom_ff <= '0;
         right_ff  <= '0;
         top_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_LEFT:   left_ff   <= $signed(csr_wr_data);
            REG_BOTTOM: bottom_ff <= $signed(csr_wr_data);
            REG_RIGHT:  right_ff  <= $signed(csr_wr_data);
            REG_TOP:    top_ff    <= $signed(csr_wr_data);
            default: ; // index beyond the register list: ignored
         endcase
      end
   end

   // pipeline control: everything moves unless a result is stuck on rsp
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   assign advance        = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_chan.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: differences and compare flags ----------------
   logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
   logic signed [COORD_WIDTH-1:0] cx [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] cy [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] seg_xmin, seg_xmax, seg_ymin, seg_ymax;
   logic [NUM_CORNERS-1:0]        eq_start, eq_end;
   logic [NUM_EDGES-1:0]          edge_touch, edge_box_miss;
   sgn_type                       tb_sgn, rl_sgn, lr_sgn;
   seg_flags_type                 s1_flags_in;
   logic signed [DW-1:0] seg_dx_in, seg_dy_in, dxl_in, dxr_in, dyb_in, dyt_in;

   assign ax = req_chan.start_x;
   assign ay = req_chan.start_y;
   assign bx = req_chan.end_x;
   assign by = req_chan.end_y;

   // corners: 0 left-bottom, 1 left-top, 2 right-top, 3 right-bottom
   always_comb begin
      cx[0] = left_ff;  cy[0] = bottom_ff;
      cx[1] = left_ff;  cy[1] = top_ff;
      cx[2] = right_ff; cy[2] = top_ff;
      cx[3] = right_ff; cy[3] = bottom_ff;
   end

   assign seg_xmin = (ax < bx) ? ax : bx;
   assign seg_xmax = (ax > bx) ? ax : bx;
   assign seg_ymin = (ay < by) ? ay : by;
   assign seg_ymax = (ay > by) ? ay : by;

   assign seg_dx_in = DW'(bx) - DW'(ax);
   assign seg_dy_in = DW'(by) - DW'(ay);
   assign dxl_in    = DW'(left_ff) - DW'(ax);
   assign dxr_in    = DW'(right_ff) - DW'(ax);
   assign dyb_in    = DW'(bottom_ff) - DW'(ay);
   assign dyt_in    = DW'(top_ff) - DW'(ay);

   genvar gc, ge;
   generate
      for (gc = 0; gc < NUM_CORNERS; gc++) begin : g_corner_eq
         assign eq_start[gc] = (ax == cx[gc]) && (ay == cy[gc]);
         assign eq_end[gc]   = (bx == cx[gc]) && (by == cy[gc]);
      end
      // edge e runs from corner e to corner e+1 (wrapping)
      for (ge = 0; ge < NUM_EDGES; ge++) begin : g_edge
         localparam int Q = (ge + 1) % NUM_CORNERS;
         logic signed [COORD_WIDTH-1:0] exmin, exmax, eymin, eymax;
         assign exmin = (cx[ge] < cx[Q]) ? cx[ge] : cx[Q];
         assign exmax = (cx[ge] > cx[Q]) ? cx[ge] : cx[Q];
         assign eymin = (cy[ge] < cy[Q]) ? cy[ge] : cy[Q];
         assign eymax = (cy[ge] > cy[Q]) ? cy[ge] : cy[Q];
         assign edge_touch[ge] =
            eq_start[ge] | eq_end[ge] | eq_start[Q] | eq_end[Q];
         assign edge_box_miss[ge] =
            (exmax < seg_xmin) || (seg_xmax < exmin) ||
            (eymax < seg_ymin) || (seg_ymax < eymin);
      end
   endgenerate

   // edge-direction crosses: one edge component is zero, so each is a
   // product of two difference signs
   assign tb_sgn = sgn_from_cmp(top_ff < bottom_ff, top_ff == bottom_ff);
   assign rl_sgn = sgn_from_cmp(right_ff < left_ff, right_ff == left_ff);
   assign lr_sgn = sgn_from_cmp(left_ff < right_ff, left_ff == right_ff);

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         s1_flags_in.edges[e].touch    = edge_touch[e];
         s1_flags_in.edges[e].box_miss = edge_box_miss[e];
      end
      // left edge: -(x - l)(t - b)
      s1_flags_in.edges[0].d3 = sgn_mul(sgn_from_cmp(left_ff < ax, left_ff == ax), tb_sgn);
      s1_flags_in.edges[0].d4 = sgn_mul(sgn_from_cmp(left_ff < bx, left_ff == bx), tb_sgn);
      // top edge: (r - l)(y - t)
      s1_flags_in.edges[1].d3 = sgn_mul(rl_sgn, sgn_from_cmp(ay < top_ff, ay == top_ff));
      s1_flags_in.edges[1].d4 = sgn_mul(rl_sgn, sgn_from_cmp(by < top_ff, by == top_ff));
      // right edge: (x - r)(t - b)
      s1_flags_in.edges[2].d3 = sgn_mul(sgn_from_cmp(ax < right_ff, ax == right_ff), tb_sgn);
      s1_flags_in.edges[2].d4 = sgn_mul(sgn_from_cmp(bx < right_ff, bx == right_ff), tb_sgn);
      // bottom edge: (l - r)(y - b)
      s1_flags_in.edges[3].d3 = sgn_mul(lr_sgn, sgn_from_cmp(ay < bottom_ff, ay == bottom_ff));
      s1_flags_in.edges[3].d4 = sgn_mul(lr_sgn, sgn_from_cmp(by < bottom_ff, by == bottom_ff));

      // wholly beyond one side
      s1_flags_in.reject = (ax < left_ff && bx < left_ff) ||
                           (ay < bottom_ff && by < bottom_ff) ||
                           (ax > right_ff && bx > right_ff) ||
                           (ay > top_ff && by > top_ff);
      // both endpoints inside, edges included
      s1_flags_in.both_in = (ax >= left_ff && ax <= right_ff &&
                             ay >= bottom_ff && ay <= top_ff) &&
                            (bx >= left_ff && bx <= right_ff &&
                             by >= bottom_ff && by <= top_ff);
   end

   logic signed [DW-1:0] seg_dx_ff, seg_dy_ff, dxl_ff, dxr_ff, dyb_ff, dyt_ff;
   seg_flags_type        s1_flags_ff, s2_flags_ff, s3_flags_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         seg_dx_ff   <= seg_dx_in;
         seg_dy_ff   <= seg_dy_in;
         dxl_ff      <= dxl_in;
         dxr_ff      <= dxr_in;
         dyb_ff      <= dyb_in;
         dyt_ff      <= dyt_in;
         s1_flags_ff <= s1_flags_in;
         s2_flags_ff <= s1_flags_ff;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   // ---------------- stages 2 and 3: corner cross-product signs ------------
   sgn_type [NUM_CORNERS-1:0] corner_sgn;

   sri_cross #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_cross (
      .clock      (clock),
      .enable     (advance),
      .seg_dx     (seg_dx_ff),
      .seg_dy     (seg_dy_ff),
      .dx_left    (dxl_ff),
      .dx_right   (dxr_ff),
      .dy_bottom  (dyb_ff),
      .dy_top     (dyt_ff),
      .corner_sgn (corner_sgn)
   );

   // ---------------- stage 4: per-edge decision into rsp register ----------
   logic [NUM_EDGES-1:0] edge_hit;
   logic                 hit_in, hit_ff;

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         sgn_type s12, s34;
         s12 = sgn_mul(corner_sgn[e], corner_sgn[(e + 1) % NUM_CORNERS]);
         s34 = sgn_mul(s3_flags_ff.edges[e].d3, s3_flags_ff.edges[e].d4);
         if (sgn_pos(s12) || sgn_pos(s34)) begin
            edge_hit[e] = 1'b0;
         end else if (s12.neg && s34.neg) begin
            edge_hit[e] = 1'b1;
         end else if (s3_flags_ff.edges[e].touch) begin
            edge_hit[e] = 1'b1;
         end else begin
            // collinear or touching: overlap of bounding boxes decides
            edge_hit[e] = ~s3_flags_ff.edges[e].box_miss;
         end
      end
      if (s3_flags_ff.reject) begin
         hit_in = 1'b0;
      end else if (s3_flags_ff.both_in) begin
         hit_in = 1'b1;
      end else begin
         hit_in = |edge_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit   = hit_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_both_in_never_rejected, clock, reset,
      s1_valid_ff && s1_flags_ff.both_in, !s1_flags_ff.reject)
   `ASSERT_NEXT(a_stage_moves_on, clock, reset,
      s2_valid_ff && advance, s3_valid_ff)
   `ASSERT_NEXT(a_stall_holds_stage, clock, reset,
      s3_valid_ff && !advance, s3_valid_ff && $stable(s3_flags_ff))

endmodule

`default_nettype wire
